// ===== rtl/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Multilevel priority queue package
// Sizes, command and status codes shared by the priority queue RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpq_pkg;

    // Queue geometry
    localparam int LEVELS      = 8;
    localparam int LEVEL_DEPTH = 16;

    localparam int LEVEL_W = $clog2(LEVELS);
    localparam int SLOT_W  = $clog2(LEVEL_DEPTH);
    localparam int COUNT_W = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W  = LEVEL_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Field widths
    localparam int DATA_W = 32;
    localparam int PRIO_W = 4;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Advance a slot pointer, wrapping at the level depth
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] result;
        if (slot == SLOT_W'(LEVEL_DEPTH - 1))
        begin
            result = '0;
        end
        else
        begin
            result = slot + SLOT_W'(1);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/multilevel_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Multilevel priority queue
// One FIFO per priority level; remove takes the oldest value of the most
// urgent non-empty level.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the result stream is not
// stalled, and returns exactly one result transaction for each. An accepted
// item sits in an input register; when it moves on to the output register, a
// lowest-set-bit grant over the per-level non-empty flags picks the level,
// the single-port value store (LEVELS x LEVEL_DEPTH words) is written or
// read once, and status and the empty flag go into the output register with
// the read data. The value store is not cleared at reset; only written
// entries are ever read. Write active_levels only while the block is idle.
`default_nettype none

module multilevel_priority_queue_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration: active_levels
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mlpq_pkg::CFG_W-1:0] cfg_data,

    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [3:0] priority_level, [35:4] element_in, rest 0
    input  wire logic [0:0]  s_axis_tuser,   // [0] command

    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] element_out, [32] queue_empty, rest 0
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int LEVELS  = mlpq_pkg::LEVELS;
    localparam int SLOT_W  = mlpq_pkg::SLOT_W;
    localparam int LEVEL_W = mlpq_pkg::LEVEL_W;
    localparam int COUNT_W = mlpq_pkg::COUNT_W;
    localparam int ADDR_W  = mlpq_pkg::ADDR_W;
    localparam int DATA_W  = mlpq_pkg::DATA_W;
    localparam int PRIO_W  = mlpq_pkg::PRIO_W;
    localparam int CFG_W   = mlpq_pkg::CFG_W;

    // Configuration register
    logic [CFG_W-1:0] active_levels_reg;

    // Input register
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    mlpq_pkg::cmd_t       s1_cmd_reg;
    logic [PRIO_W-1:0]    s1_level_reg;
    logic [DATA_W-1:0]    s1_data_reg;

    // Per-level FIFO pointers and counts
    logic [SLOT_W-1:0]  head_reg  [LEVELS];
    logic [SLOT_W-1:0]  head_next [LEVELS];
    logic [SLOT_W-1:0]  tail_reg  [LEVELS];
    logic [SLOT_W-1:0]  tail_next [LEVELS];
    logic [COUNT_W-1:0] count_reg  [LEVELS];
    logic [COUNT_W-1:0] count_next [LEVELS];

    // Value store
    logic [DATA_W-1:0] mem [mlpq_pkg::MEM_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mlpq_pkg::status_t    out_status_reg;
    logic                 out_empty_reg;
    logic                 out_take_reg;

    // Decode signals
    logic              s_accept;
    logic              advance;
    logic              is_insert;
    logic [LEVELS-1:0] active_mask;
    logic [LEVELS-1:0] lvl_hit;
    logic [LEVELS-1:0] full_vec;
    logic [LEVELS-1:0] cand;
    logic [LEVELS-1:0] grant;
    logic [LEVELS-1:0] nonzero_next;
    logic              ins_valid;
    logic              ins_full;
    logic              do_insert;
    logic              do_remove;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] mem_addr;
    mlpq_pkg::status_t status_next;
    logic              empty_next;

    // Handshakes
    assign cfg_ready     = 1'b1;
    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_levels_reg <= mlpq_pkg::ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_levels_reg <= cfg_data;
        end
    end

    // Per-level flags: active, addressed, full, candidate for remove
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            active_mask[i] = int'(active_levels_reg) > i;
            lvl_hit[i]     = int'(s1_level_reg) == i;
            full_vec[i]    = count_reg[i] == COUNT_W'(mlpq_pkg::LEVEL_DEPTH);
            cand[i]        = active_mask[i] && (count_reg[i] != '0);
        end
    end

    // Lowest-numbered non-empty level wins
    assign grant = cand & (~cand + LEVELS'(1));

    assign is_insert = s1_cmd_reg == mlpq_pkg::CMD_INSERT;
    assign ins_valid = |(lvl_hit & active_mask);
    assign ins_full  = |(lvl_hit & full_vec);
    assign do_insert = advance && is_insert && ins_valid && !ins_full;
    assign do_remove = advance && !is_insert && (|cand);

    // Status of the operation
    always_comb
    begin
        if (is_insert)
        begin
            if (!ins_valid)
            begin
                status_next = mlpq_pkg::ST_INVALID;
            end
            else if (ins_full)
            begin
                status_next = mlpq_pkg::ST_FULL;
            end
            else
            begin
                status_next = mlpq_pkg::ST_OK;
            end
        end
        else if (|cand)
        begin
            status_next = mlpq_pkg::ST_OK;
        end
        else
        begin
            status_next = mlpq_pkg::ST_UNDERFLOW;
        end
    end

    // Select the store address of the addressed or granted level
    always_comb
    begin
        wr_addr = '0;
        rd_addr = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (lvl_hit[i])
            begin
                wr_addr = {LEVEL_W'(i), tail_reg[i]};
            end
            if (grant[i])
            begin
                rd_addr = {LEVEL_W'(i), head_reg[i]};
            end
        end
        mem_addr = is_insert ? wr_addr : rd_addr;
    end

    // Advance pointers and counts of the touched level
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (do_insert && lvl_hit[i])
            begin
                tail_next[i]  = mlpq_pkg::next_slot(tail_reg[i]);
                count_next[i] = count_reg[i] + COUNT_W'(1);
            end
            if (do_remove && grant[i])
            begin
                head_next[i]  = mlpq_pkg::next_slot(head_reg[i]);
                count_next[i] = count_reg[i] - COUNT_W'(1);
            end
            nonzero_next[i] = count_next[i] != '0;
        end
    end

    assign empty_next = ~|(nonzero_next & active_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // Valid flags of the input and output registers
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_cmd_reg   <= mlpq_pkg::cmd_t'(s_axis_tuser[0]);
            s1_level_reg <= s_axis_tdata[PRIO_W-1:0];
            s1_data_reg  <= s_axis_tdata[PRIO_W+DATA_W-1:PRIO_W];
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
            out_empty_reg  <= empty_next;
            out_take_reg   <= do_remove;
        end
    end

    // Value store: one access per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            mem[mem_addr] <= s1_data_reg;
        end
        if (do_remove)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Drive the result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'b0, out_empty_reg, out_take_reg ? rd_data_reg : DATA_W'(0)};

`ifndef SYNTHESIS
    // A failed operation never returns a value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != mlpq_pkg::ST_OK) |-> m_axis_tdata[DATA_W-1:0] == '0)
        else $error("value returned with a failing status");

    // Underflow only when every active level is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == mlpq_pkg::ST_UNDERFLOW) |-> m_axis_tdata[DATA_W])
        else $error("underflow reported on a non-empty queue");

    // A full level means the queue is not empty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == mlpq_pkg::ST_FULL) |-> !m_axis_tdata[DATA_W])
        else $error("level full reported on an empty queue");

    // Input stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the output is free");
`endif

endmodule

`default_nettype wire
